// File: rtl/core/correlating_branch_predictor_top_macros.svh
// Assertion helpers for the correlating branch predictor.
`ifndef CORRELATING_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define CORRELATING_BRANCH_PREDICTOR_TOP_MACROS_SVH

// Checked only outside reset.
`define CBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cbp_pkg.sv
`timescale 1ns / 1ps

package cbp_pkg;

  typedef struct packed {
    logic clear;   // table clearing sweep active
    logic load;    // branch transfer: capture inputs, read table entry
    logic update;  // write back entry, bump counters, shift history
  } cbp_cmd_t;

  typedef struct packed {
    logic clear_last;  // sweep is at the last table entry
  } cbp_status_t;

endpackage

// File: rtl/core/cbp_ctrl.sv
`timescale 1ns / 1ps
`include "correlating_branch_predictor_top_macros.svh"

module cbp_ctrl
  import cbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cbp_status_t status,
  output cbp_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.load   = (state == ST_IDLE) && start;
  assign cmd.update = (state == ST_UPDATE);
  assign busy       = (state != ST_IDLE);

  `CBP_ASSERT(a_load_then_update, cmd.load |=> cmd.update && busy, "load not followed by update")
  `CBP_ASSERT(a_update_one_cycle, cmd.update |=> !cmd.update && !cmd.clear,
              "update lasted more than one cycle")
  `CBP_ASSERT_ALWAYS(a_reset_clears, rst |=> cmd.clear, "no clearing sweep after reset")

endmodule

// File: rtl/core/cbp_dp.sv
`timescale 1ns / 1ps
`include "correlating_branch_predictor_top_macros.svh"

module cbp_dp
  import cbp_pkg::*;
#(
  parameter int MAX_ADDRESS_BITS = 8,
  parameter int MAX_HISTORY_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  cbp_cmd_t    cmd,
  output cbp_status_t status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic [31:0] branch_address,
  input  logic        taken,
  output logic        done,
  output logic        predicted_taken,
  output logic [31:0] correct_count,
  output logic [31:0] total_count,
  output logic [8:0]  entries_used
);

  localparam int IDX_BITS   = MAX_ADDRESS_BITS + MAX_HISTORY_BITS;
  localparam int ADDR_SLOTS = 1 << MAX_ADDRESS_BITS;
  localparam int TBL_DEPTH  = 1 << IDX_BITS;

  localparam logic [1:0] REG_COUNTER_TWO_BIT = 2'd0;
  localparam logic [1:0] REG_HISTORY_LENGTH  = 2'd1;
  localparam logic [1:0] REG_ADDRESS_LENGTH  = 2'd2;

  // 2-bit counter states
  localparam logic [1:0] ENT_0 = 2'd0;
  localparam logic [1:0] ENT_1 = 2'd1;
  localparam logic [1:0] ENT_2 = 2'd2;
  localparam logic [1:0] ENT_3 = 2'd3;

  logic       counter_two_bit;
  logic [2:0] history_length;
  logic [3:0] address_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_two_bit <= 1'b1;
      history_length  <= 3'd2;
      address_length  <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNTER_TWO_BIT: counter_two_bit <= cfg_data[0];
        REG_HISTORY_LENGTH:  history_length  <= cfg_data[2:0];
        REG_ADDRESS_LENGTH:  address_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lengths past the maximum saturate: mask bits above the max don't exist.
  logic [MAX_HISTORY_BITS-1:0] hmask;
  logic [MAX_ADDRESS_BITS-1:0] amask;

  always_comb begin
    for (int i = 0; i < MAX_HISTORY_BITS; i++) hmask[i] = (int'(history_length) > i);
    for (int i = 0; i < MAX_ADDRESS_BITS; i++) amask[i] = (int'(address_length) > i);
  end

  logic [MAX_HISTORY_BITS-1:0] history;
  logic [MAX_ADDRESS_BITS-1:0] addr_c;
  logic [MAX_HISTORY_BITS-1:0] hist_c;
  logic [IDX_BITS-1:0]         idx_c;

  assign addr_c = branch_address[MAX_ADDRESS_BITS-1:0] & amask;
  assign hist_c = history & hmask;
  assign idx_c  = {addr_c, hist_c};

  // Captured branch
  logic [MAX_ADDRESS_BITS-1:0] addr_q;
  logic [IDX_BITS-1:0]         idx_q;
  logic                        taken_q;
  logic [1:0]                  entry_q;
  logic                        seen_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q  <= addr_c;
      idx_q   <= idx_c;
      taken_q <= taken;
    end
  end

  // Clearing sweep address
  logic [IDX_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clear_last = (clr_addr == IDX_BITS'(TBL_DEPTH - 1));

  // Entry update
  logic       pred;
  logic       hit;
  logic [1:0] entry_new;

  always_comb begin
    if (counter_two_bit) begin
      pred = entry_q[1];
      if (taken_q) entry_new = (entry_q == ENT_0) ? ENT_1 : ENT_3;
      else         entry_new = (entry_q == ENT_3) ? ENT_2 : ENT_0;
    end else begin
      pred      = (entry_q != ENT_0);
      entry_new = (pred == taken_q) ? entry_q : {1'b0, taken_q};
    end
    hit = (pred == taken_q);
  end

  // Pattern table
  logic [1:0] pattern_table [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      pattern_table[clr_addr] <= ENT_0;
    end else if (cmd.update) begin
      pattern_table[idx_q] <= entry_new;
    end
    if (cmd.load) begin
      entry_q <= pattern_table[idx_c];
    end
  end

  // Address seen bits; the table sweep covers every address slot
  logic seen_mem [ADDR_SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      seen_mem[clr_addr[IDX_BITS-1:MAX_HISTORY_BITS]] <= 1'b0;
    end else if (cmd.update) begin
      seen_mem[addr_q] <= 1'b1;
    end
    if (cmd.load) begin
      seen_q <= seen_mem[addr_c];
    end
  end

  // Counters, history
  always_ff @(posedge clk) begin
    if (rst) begin
      history       <= '0;
      correct_count <= '0;
      total_count   <= '0;
      entries_used  <= '0;
      done          <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        if (!seen_q) entries_used <= entries_used + 9'd1;
        if (hit && (correct_count != '1)) correct_count <= correct_count + 32'd1;
        if (total_count != '1) total_count <= total_count + 32'd1;
        history <= MAX_HISTORY_BITS'({history, taken_q}) & hmask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) predicted_taken <= pred;
  end

  `CBP_ASSERT(a_done_after_update, cmd.update |=> done, "result strobe missing after update")
  `CBP_ASSERT(a_correct_le_total, correct_count <= total_count,
              "correct count exceeds total count")
  `CBP_ASSERT(a_done_counts, done |-> total_count != 32'd0, "result with zero branch count")

endmodule

// File: rtl/core/correlating_branch_predictor_top.sv
`timescale 1ns / 1ps

// Correlating branch predictor with global history. A resolved branch is
// transferred at a clock edge where start is high and busy is low; its
// result passes through the update state and the done register, and done is
// high for exactly one cycle. The receiver cannot stall, so results must be
// captured while done is high. A branch reads its pattern table entry into a
// register, then writes the entry back (single-port table read-modify-write).
// A new branch may be transferred in the cycle its predecessor's result shows,
// not before, as busy stays high until then. After reset the table is cleared
// one entry a cycle, all 2^(MAX_ADDRESS_BITS + MAX_HISTORY_BITS) entries (4096
// with the defaults), with busy high; configuration writes are taken at any time.
module correlating_branch_predictor_top
  import cbp_pkg::*;
#(
  parameter int MAX_ADDRESS_BITS = 8,
  parameter int MAX_HISTORY_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] branch_address,
  input  logic        taken,
  output logic        done,
  output logic        predicted_taken,
  output logic [31:0] correct_count,
  output logic [31:0] total_count,
  output logic [8:0]  entries_used,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  cbp_cmd_t    cmd;
  cbp_status_t status;

  cbp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cbp_dp #(
    .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS),
    .MAX_HISTORY_BITS (MAX_HISTORY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .branch_address  (branch_address),
    .taken           (taken),
    .done            (done),
    .predicted_taken (predicted_taken),
    .correct_count   (correct_count),
    .total_count     (total_count),
    .entries_used    (entries_used)
  );

endmodule
